// ===== src/yq2rgb_pkg.sv =====
// Shared types, coefficients and helpers for the YUV 4:2:0 quad to RGB32 converter.
// No dependencies.
package yq2rgb_pkg;

  localparam logic RANGE_STUDIO = 1'b0;
  localparam logic RANGE_FULL   = 1'b1;

  localparam int SampleW  = 8;
  localparam int PixelW   = 32;
  localparam int InDataW  = 6 * SampleW;
  localparam int OutDataW = 4 * PixelW;

  // studio range: 16-bit fractional fixed point
  localparam int StudioW = 28;
  localparam int StudioShift = 16;
  localparam logic signed [StudioW-1:0] C_Y   = 28'sd76309;
  localparam logic signed [StudioW-1:0] C_R_V = 28'sd104597;
  localparam logic signed [StudioW-1:0] C_G_U = 28'sd25675;
  localparam logic signed [StudioW-1:0] C_G_V = 28'sd53279;
  localparam logic signed [StudioW-1:0] C_B_U = 28'sd132201;
  localparam logic signed [StudioW-1:0] Y_OFFSET = 28'sd16;

  // full range: 10-bit fractional fixed point
  localparam int FullW = 20;
  localparam int FullShift = 10;
  localparam logic signed [FullW-1:0] F_R_V = 20'sd1436;
  localparam logic signed [FullW-1:0] F_G_U = 20'sd352;
  localparam logic signed [FullW-1:0] F_G_V = 20'sd731;
  localparam logic signed [FullW-1:0] F_B_U = 20'sd1815;

  localparam int ChanW = 12;

  typedef struct packed {
    logic signed [StudioW-1:0] s_r;
    logic signed [StudioW-1:0] s_g;
    logic signed [StudioW-1:0] s_b;
    logic signed [ChanW-1:0]   f_r;
    logic signed [ChanW-1:0]   f_g;
    logic signed [ChanW-1:0]   f_b;
  } chroma_terms_t;

  typedef struct packed {
    logic [SampleW-1:0] luma_lower_right;
    logic [SampleW-1:0] luma_lower_left;
    logic [SampleW-1:0] luma_upper_right;
    logic [SampleW-1:0] luma_upper_left;
    logic [SampleW-1:0] chroma_v;
    logic [SampleW-1:0] chroma_u;
  } quad_t;

  function automatic logic [7:0] sat8(input logic signed [ChanW-1:0] x);
    logic [7:0] res;
    if (x < 0) begin
      res = 8'h00;
    end else if (x > 12'sd255) begin
      res = 8'hFF;
    end else begin
      res = x[7:0];
    end
    return res;
  endfunction

endpackage

// ===== src/yuv420_quad_to_rgb32_unit.sv =====
// Top level of the YUV 4:2:0 quad to RGB32 converter (BT.601 coefficients).
// Depends on yq2rgb_pkg, yq2rgb_chroma and yq2rgb_pixel.
//
// Each beat in carries one quad (U, V and four luma samples); each beat out carries the four
// packed 32-bit pixels. The block takes one quad every cycle while the output is not stalled.
// An accepted quad is held in the input register, converted combinationally, and its pixels
// are captured in the result register. A stalled output holds the result register and backs
// up into the input register. range_mode selects studio range with alpha 0xFF in the low byte,
// or full range 0RGB; write it only while no quad is in flight.
module yuv420_quad_to_rgb32_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // chroma_u, chroma_v, luma_upper_left, luma_upper_right, luma_lower_left, luma_lower_right
  input  logic [47:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pixel_upper_left, pixel_upper_right, pixel_lower_left, pixel_lower_right
  output logic [127:0] m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_data
);
  import yq2rgb_pkg::*;

  logic                       in_valid;
  quad_t                      in_data;
  logic                       out_valid;
  logic [OutDataW-1:0]        out_data;
  logic                       range_mode;
  logic                       advance;
  chroma_terms_t              terms;
  logic [3:0][PixelW-1:0]     pix;
  logic [3:0][SampleW-1:0]    lumas;

  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      out_valid  <= 1'b0;
      range_mode <= RANGE_STUDIO;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
      if (cfg_valid && cfg_ready) begin
        range_mode <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data <= quad_t'(s_axis_tdata);
    end
    if (advance && in_valid) begin
      out_data <= pix;
    end
  end

  yq2rgb_chroma u_chroma (
    .chroma_u (in_data.chroma_u),
    .chroma_v (in_data.chroma_v),
    .terms    (terms)
  );

  assign lumas = {in_data.luma_lower_right, in_data.luma_lower_left,
                  in_data.luma_upper_right, in_data.luma_upper_left};

  for (genvar k = 0; k < 4; k++) begin : g_pix
    yq2rgb_pixel u_pixel (
      .luma       (lumas[k]),
      .range_mode (range_mode),
      .terms      (terms),
      .pixel      (pix[k])
    );
  end

endmodule

// ===== src/yq2rgb_chroma.sv =====
// Chroma contribution terms shared by the four pixels of a quad, both ranges.
// Depends on yq2rgb_pkg.
module yq2rgb_chroma (
  input  logic [7:0]                chroma_u,
  input  logic [7:0]                chroma_v,
  output yq2rgb_pkg::chroma_terms_t terms
);
  import yq2rgb_pkg::*;

  logic signed [7:0]         uc;
  logic signed [7:0]         vc;
  logic signed [StudioW-1:0] uc_s;
  logic signed [StudioW-1:0] vc_s;
  logic signed [FullW-1:0]   uc_f;
  logic signed [FullW-1:0]   vc_f;
  logic signed [FullW-1:0]   fr_p;
  logic signed [FullW-1:0]   fgu_p;
  logic signed [FullW-1:0]   fgv_p;
  logic signed [FullW-1:0]   fb_p;

  // offset-128 to two's complement: flip the top bit
  assign uc = {~chroma_u[7], chroma_u[6:0]};
  assign vc = {~chroma_v[7], chroma_v[6:0]};

  assign uc_s = StudioW'(uc);
  assign vc_s = StudioW'(vc);
  assign uc_f = FullW'(uc);
  assign vc_f = FullW'(vc);

  assign terms.s_r = C_R_V * vc_s;
  assign terms.s_g = -(C_G_U * uc_s) - (C_G_V * vc_s);
  assign terms.s_b = C_B_U * uc_s;

  assign fr_p  = F_R_V * vc_f;
  assign fgu_p = F_G_U * uc_f;
  assign fgv_p = F_G_V * vc_f;
  assign fb_p  = F_B_U * uc_f;

  assign terms.f_r = ChanW'(fr_p >>> FullShift);
  assign terms.f_g = -ChanW'(fgu_p >>> FullShift) - ChanW'(fgv_p >>> FullShift);
  assign terms.f_b = ChanW'(fb_p >>> FullShift);

endmodule

// ===== src/yq2rgb_pixel.sv =====
// One pixel: luma plus shared chroma terms, floor shift, saturate and pack.
// Depends on yq2rgb_pkg.
module yq2rgb_pixel (
  input  logic [7:0]                luma,
  input  logic                      range_mode,
  input  yq2rgb_pkg::chroma_terms_t terms,
  output logic [31:0]               pixel
);
  import yq2rgb_pkg::*;

  logic signed [StudioW-1:0] ys;
  logic signed [StudioW-1:0] sum_r;
  logic signed [StudioW-1:0] sum_g;
  logic signed [StudioW-1:0] sum_b;
  logic signed [ChanW-1:0]   yf;
  logic [7:0]                sr, sg, sb;
  logic [7:0]                fr, fg, fb;

  assign ys    = C_Y * (StudioW'({1'b0, luma}) - Y_OFFSET);
  assign sum_r = ys + terms.s_r;
  assign sum_g = ys + terms.s_g;
  assign sum_b = ys + terms.s_b;

  assign sr = sat8(ChanW'(sum_r >>> StudioShift));
  assign sg = sat8(ChanW'(sum_g >>> StudioShift));
  assign sb = sat8(ChanW'(sum_b >>> StudioShift));

  assign yf = ChanW'({1'b0, luma});
  assign fr = sat8(yf + terms.f_r);
  assign fg = sat8(yf + terms.f_g);
  assign fb = sat8(yf + terms.f_b);

  always_comb begin
    case (range_mode)
      RANGE_FULL: pixel = {8'h00, fr, fg, fb};
      default:    pixel = {sr, sg, sb, 8'hFF};
    endcase
  end

endmodule

// ===== src/yq2rgb_checker.sv =====
// Port-level checks for the YUV 4:2:0 quad to RGB32 converter, bound to the top level.
// No package dependency.
module yq2rgb_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output beat changed");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("accepted quad did not reach the output in two cycles");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input not ready while output is empty");

  a_fixed_byte: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[7:0] == 8'hFF) || (m_axis_tdata[31:24] == 8'h00))
    else $error("pixel word has neither alpha nor zero top byte");

endmodule

bind yuv420_quad_to_rgb32_unit yq2rgb_checker u_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for yuv420_quad_to_rgb32_unit: quads in, four packed pixels out.
// Depends on yq2rgb_pkg for the quad layout and range codes. It carries its own pixel predictor
// and runs directed and random quads in both ranges, with random stalls on either side.
module tb;
  import yq2rgb_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 8;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // chroma_u, chroma_v, luma_upper_left, luma_upper_right, luma_lower_left, luma_lower_right
  logic [47:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // pixel_upper_left, pixel_upper_right, pixel_lower_left, pixel_lower_right
  logic [127:0] m_axis_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic         cfg_data = 1'b0;

  logic         range_sel = RANGE_STUDIO;
  logic [127:0] pixel_quads_due[$];
  bit           no_idle = 1'b0;
  int           stall_left = 0;
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           studio_quads = 0;
  int           full_quads = 0;
  int           range_writes = 0;

  yuv420_quad_to_rgb32_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] clamp_channel(input int x);
    if (x < 0) return 8'h00;
    if (x > 255) return 8'hFF;
    return x[7:0];
  endfunction

  function automatic logic [31:0] pixel_word(input logic mode, input logic [7:0] y,
                                             input int uc, input int vc);
    int yi;
    int ys;
    logic [7:0] r, g, b;
    yi = int'(y);
    if (mode == RANGE_FULL) begin
      r = clamp_channel(yi + ((1436 * vc) >>> 10));
      g = clamp_channel(yi - ((352 * uc) >>> 10) - ((731 * vc) >>> 10));
      b = clamp_channel(yi + ((1815 * uc) >>> 10));
      return {8'h00, r, g, b};
    end
    ys = 76309 * (yi - 16);
    r = clamp_channel((ys + 104597 * vc) >>> 16);
    g = clamp_channel((ys - 25675 * uc - 53279 * vc) >>> 16);
    b = clamp_channel((ys + 132201 * uc) >>> 16);
    return {r, g, b, 8'hFF};
  endfunction

  function automatic logic [127:0] convert_quad(input logic mode, input quad_t q);
    int uc;
    int vc;
    uc = int'(q.chroma_u) - 128;
    vc = int'(q.chroma_v) - 128;
    return {pixel_word(mode, q.luma_lower_right, uc, vc),
            pixel_word(mode, q.luma_lower_left, uc, vc),
            pixel_word(mode, q.luma_upper_right, uc, vc),
            pixel_word(mode, q.luma_upper_left, uc, vc)};
  endfunction

  function automatic quad_t make_quad(input logic [7:0] u, v, ul, ur, ll, lr);
    quad_t q;
    q.chroma_u = u;
    q.chroma_v = v;
    q.luma_upper_left = ul;
    q.luma_upper_right = ur;
    q.luma_lower_left = ll;
    q.luma_lower_right = lr;
    return q;
  endfunction

  function automatic logic [7:0] pick_sample();
    if ($urandom_range(0, 7) != 0) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h10;
      3: return 8'hEB;
      4: return 8'h80;
      default: return 8'h7F;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH @%0d: %s", cycle_count, msg);
  endtask

  task automatic check_pixels(input logic [127:0] got);
    logic [127:0] want;
    string names[4];
    names = '{"pixel_upper_left", "pixel_upper_right", "pixel_lower_left", "pixel_lower_right"};
    if (pixel_quads_due.size() == 0) begin
      report_mismatch($sformatf("output beat %h with no quad pending", got));
      return;
    end
    want = pixel_quads_due.pop_front();
    for (int k = 0; k < 4; k++) begin
      if (got[32*k +: 32] !== want[32*k +: 32])
        report_mismatch($sformatf("%s got %h expected %h", names[k],
                                  got[32*k +: 32], want[32*k +: 32]));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_pixels(m_axis_tdata);
        stall_left = no_idle ? 0 : $urandom_range(0, 3);
      end
      if (stall_left > 0 && !no_idle) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d quads pending", cycle_count,
               pixel_quads_due.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_quad(input quad_t q);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= q;
    do @(posedge clk); while (!s_axis_tready);
    pixel_quads_due.push_back(convert_quad(range_sel, q));
    if (range_sel == RANGE_FULL) full_quads++;
    else studio_quads++;
  endtask

  // drop the stream, let the pipe empty, then write the range register
  task automatic write_range(input logic mode);
    s_axis_tvalid <= 1'b0;
    while (pixel_quads_due.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    range_sel = mode;
    range_writes++;
  endtask

  task automatic test_reset_default();
    send_quad(make_quad(8'h80, 8'h80, 8'h00, 8'h10, 8'hEB, 8'hFF));
    send_quad(make_quad(8'h00, 8'hFF, 8'h40, 8'h80, 8'hC0, 8'hFF));
  endtask

  // neutral chroma, chroma corners, saturation both ways, negative floor near centre
  task automatic test_directed_extremes();
    send_quad(make_quad(8'h80, 8'h80, 8'h00, 8'h10, 8'hEB, 8'hFF));
    send_quad(make_quad(8'h00, 8'h00, 8'h00, 8'hFF, 8'h10, 8'hEB));
    send_quad(make_quad(8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h10, 8'hEB));
    send_quad(make_quad(8'h00, 8'hFF, 8'h80, 8'h80, 8'h80, 8'h80));
    send_quad(make_quad(8'hFF, 8'h00, 8'h80, 8'h80, 8'h80, 8'h80));
    send_quad(make_quad(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA));
    send_quad(make_quad(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55));
    send_quad(make_quad(8'h7F, 8'h81, 8'h01, 8'hFE, 8'h0F, 8'h11));
    send_quad(make_quad(8'h81, 8'h7F, 8'h10, 8'h11, 8'hEA, 8'hEC));
    send_quad(make_quad(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_quad(make_quad(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
  endtask

  task automatic test_random_quads(input int count);
    for (int n = 0; n < count; n++)
      send_quad(make_quad(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                          pick_sample(), pick_sample()));
  endtask

  task automatic test_back_to_back(input int count);
    no_idle = 1'b1;
    test_random_quads(count);
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_default();
    write_range(RANGE_FULL);
    test_directed_extremes();
    write_range(RANGE_STUDIO);
    test_directed_extremes();
    test_random_quads(400);
    write_range(RANGE_FULL);
    test_random_quads(400);
    test_back_to_back(200);
    write_range(RANGE_STUDIO);
    test_back_to_back(200);
    write_range(RANGE_FULL);
    test_random_quads(225);
    write_range(RANGE_STUDIO);
    test_random_quads(225);

    s_axis_tvalid <= 1'b0;
    while (pixel_quads_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    $display("Converted %0d studio-range and %0d full-range quads across %0d range writes,",
             studio_quads, full_quads, range_writes);
    $display("with random and back-to-back stalls on both streams; %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
